FILE: rtl/core/bmmf_pkg.sv
// ----------------------------------------------------------------------------
// bmmf_pkg
// Shared types and constants of the boot memory map filter.
// ----------------------------------------------------------------------------
package bmmf_pkg;

  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Tag and entry codes
  localparam logic [31:0] TAG_END       = 32'd0;
  localparam logic [31:0] TAG_MMAP      = 32'd6;
  localparam logic [31:0] ENTRY_USABLE  = 32'd1;
  // Size limits in bytes
  localparam logic [31:0] TAG_HDR_BYTES = 32'd8;
  localparam logic [31:0] MMAP_MIN      = 32'd16;
  localparam logic [31:0] ENTRY_MIN     = 32'd24;
  localparam logic [31:0] WORD_BYTES    = 32'd4;

  // Meaning of the next word of the stream
  typedef enum logic [7:0] {
    PH_WAIT  = 8'b0000_0001,
    PH_RESV  = 8'b0000_0010,
    PH_TTYPE = 8'b0000_0100,
    PH_TSIZE = 8'b0000_1000,
    PH_ESIZE = 8'b0001_0000,
    PH_EVER  = 8'b0010_0000,
    PH_ENTRY = 8'b0100_0000,
    PH_SKIP  = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic [31:0] word;
    logic        start_req;
  } bmmf_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] region_base;
    logic [ADDR_W-1:0] region_length;
  } bmmf_out_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } queue_status_t;

endpackage

FILE: rtl/core/bmmf_parser.sv
// ----------------------------------------------------------------------------
// bmmf_parser
// Front end: walks the tag stream one word per transfer and pushes one
// region record for every usable memory-map entry that is kept.
// ----------------------------------------------------------------------------
module bmmf_parser #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  bmmf_pkg::bmmf_in_t  in_data_i,
  output logic                push_o,
  output bmmf_pkg::bmmf_out_t push_data_o
);
  import bmmf_pkg::*;

  localparam int unsigned KeptW = $clog2(MAX_ENTRIES + 1);

  phase_e           phase_q, phase_d;
  logic [31:0]      byte_offset_q, byte_offset_d;
  logic [31:0]      total_q, total_d;
  logic             is_mmap_q, is_mmap_d;
  logic [31:0]      left_q, left_d;
  logic [31:0]      entry_bytes_q, entry_bytes_d;
  logic [29:0]      idx_q, idx_d;
  logic [63:0]      base_q, base_d;
  logic [63:0]      length_q, length_d;
  logic [KeptW-1:0] kept_q, kept_d;
  logic             done_q, done_d;

  // Next-state logic for one accepted word
  always_comb begin
    logic [32:0] next_off;
    logic [32:0] ent_end;
    logic [31:0] w;
    logic        body;
    logic        stop;
    phase_d       = phase_q;
    byte_offset_d = byte_offset_q;
    total_d       = total_q;
    is_mmap_d     = is_mmap_q;
    left_d        = left_q;
    entry_bytes_d = entry_bytes_q;
    idx_d         = idx_q;
    base_d        = base_q;
    length_d      = length_q;
    kept_d        = kept_q;
    done_d        = done_q;
    push_o        = 1'b0;
    w             = in_data_i.word;
    next_off      = {1'b0, byte_offset_q} + {1'b0, WORD_BYTES};
    ent_end       = {({1'b0, idx_q} + 31'd1), 2'b00};
    body          = 1'b0;
    stop          = 1'b0;

    if (accept_i) begin
      if (in_data_i.start_req) begin
        // Total size word restarts everything
        total_d       = w;
        byte_offset_d = WORD_BYTES;
        phase_d       = PH_RESV;
        is_mmap_d     = 1'b0;
        left_d        = '0;
        entry_bytes_d = '0;
        idx_d         = '0;
        kept_d        = '0;
        done_d        = (WORD_BYTES >= w);
      end else if (!done_q) begin
        unique case (phase_q)
          PH_RESV: begin
            phase_d = PH_TTYPE;
          end
          PH_TTYPE: begin
            if (w == TAG_END) begin
              stop = 1'b1;
            end else begin
              is_mmap_d = (w == TAG_MMAP);
              phase_d   = PH_TSIZE;
            end
          end
          PH_TSIZE: begin
            if (w < TAG_HDR_BYTES) begin
              stop = 1'b1;
            end else begin
              left_d = w - TAG_HDR_BYTES;
              if (w == TAG_HDR_BYTES) begin
                phase_d = (next_off[2:0] == 3'd0) ? PH_TTYPE : PH_SKIP;
              end else if (is_mmap_q && w >= MMAP_MIN) begin
                phase_d = PH_ESIZE;
              end else begin
                phase_d = PH_SKIP;
              end
            end
          end
          PH_ESIZE: begin
            entry_bytes_d = (w >= ENTRY_MIN && w[1:0] == 2'b00) ? w : '0;
            phase_d       = PH_EVER;
            body          = 1'b1;
          end
          PH_EVER: begin
            idx_d   = '0;
            phase_d = (entry_bytes_q != '0) ? PH_ENTRY : PH_SKIP;
            body    = 1'b1;
          end
          PH_ENTRY: begin
            body = 1'b1;
            if (idx_q == '0 && entry_bytes_q > left_q) begin
              // entry does not fit: drop rest of the tag
              phase_d = PH_SKIP;
            end else begin
              case (idx_q)
                30'd0: base_d   = {32'd0, w};
                30'd1: base_d   = {w, base_q[31:0]};
                30'd2: length_d = {32'd0, w};
                30'd3: length_d = {w, length_q[31:0]};
                30'd4: begin
                  if (w == ENTRY_USABLE && kept_q < KeptW'(MAX_ENTRIES)) begin
                    push_o = 1'b1;
                    kept_d = kept_q + KeptW'(1);
                  end
                end
                default: ;
              endcase
              idx_d = (ent_end >= {1'b0, entry_bytes_q}) ? '0 : idx_q + 30'd1;
            end
          end
          PH_SKIP: begin
            body = 1'b1;
          end
          default: begin
            stop = 1'b1;
          end
        endcase

        if (stop) begin
          done_d  = 1'b1;
          phase_d = PH_WAIT;
        end else begin
          // Tag body bookkeeping and padding
          if (body) begin
            left_d = (left_q > WORD_BYTES) ? left_q - WORD_BYTES : '0;
            if (left_d == '0) begin
              phase_d = (next_off[2:0] == 3'd0) ? PH_TTYPE : PH_SKIP;
            end
          end
          // End of structure
          if (next_off >= {1'b0, total_q}) begin
            done_d  = 1'b1;
            phase_d = PH_WAIT;
          end else begin
            byte_offset_d = next_off[31:0];
          end
        end
      end
    end
  end

  assign push_data_o.slot          = SLOT_W'(kept_q);
  assign push_data_o.region_base   = base_q;
  assign push_data_o.region_length = length_q;

  // Parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_WAIT;
      byte_offset_q <= '0;
      total_q       <= '0;
      is_mmap_q     <= 1'b0;
      left_q        <= '0;
      entry_bytes_q <= '0;
      idx_q         <= '0;
      kept_q        <= '0;
      done_q        <= 1'b1;
    end else begin
      phase_q       <= phase_d;
      byte_offset_q <= byte_offset_d;
      total_q       <= total_d;
      is_mmap_q     <= is_mmap_d;
      left_q        <= left_d;
      entry_bytes_q <= entry_bytes_d;
      idx_q         <= idx_d;
      kept_q        <= kept_d;
      done_q        <= done_d;
    end
  end

  // Captured entry fields
  always_ff @(posedge clk_i) begin
    base_q   <= base_d;
    length_q <= length_d;
  end

endmodule

FILE: rtl/core/bmmf_queue.sv
// ----------------------------------------------------------------------------
// bmmf_queue
// Short FIFO of region records between the parser and the output stage.
// ----------------------------------------------------------------------------
module bmmf_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  bmmf_pkg::bmmf_out_t     push_data_i,
  input  logic                    pop_i,
  output bmmf_pkg::bmmf_out_t     pop_data_o,
  output bmmf_pkg::queue_status_t status_o
);
  import bmmf_pkg::*;

  bmmf_out_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + QCNT_W'(1);
        2'b01:   count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  assign pop_data_o     = mem_q[rd_ptr_q];
  assign status_o.count = count_q;
  assign status_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);

endmodule

FILE: rtl/core/bmmf_emitter.sv
// ----------------------------------------------------------------------------
// bmmf_emitter
// Back end: output register that drains the queue onto the result channel.
// ----------------------------------------------------------------------------
module bmmf_emitter (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bmmf_pkg::queue_status_t status_i,
  input  bmmf_pkg::bmmf_out_t     pop_data_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output bmmf_pkg::bmmf_out_t     out_data_o
);
  import bmmf_pkg::*;

  logic      valid_q;
  bmmf_out_t data_q;

  // Reload when the register is free or its transfer completes
  assign pop_o = !status_i.empty && (!valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= !status_i.empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= pop_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

FILE: rtl/core/boot_memory_map_filter.sv
// Path: a region is written into the queue when the entry's type word is
//   transferred, and is then loaded into the output register once that is free.
// Throughput: one word per cycle; the parse state updates once per word, and the
//   input stalls only while the four-entry queue is full behind a stalled output.
// Reset: asynchronous, active low; the parser ignores words until a start
//   word arrives, and the queue and output register come up empty.
// ----------------------------------------------------------------------------
// boot_memory_map_filter
// Boot information parser exporting usable RAM regions from the memory map.
// ----------------------------------------------------------------------------
module boot_memory_map_filter #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bmmf_pkg::bmmf_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bmmf_pkg::bmmf_out_t out_data_o
);
  import bmmf_pkg::*;

  logic          accept;
  logic          push;
  logic          pop;
  bmmf_out_t     push_data;
  bmmf_out_t     pop_data;
  queue_status_t q_status;

  // At most one record per word, so a free queue slot admits a word
  assign in_ready_o = !q_status.full;
  assign accept     = in_valid_i && in_ready_o;

  bmmf_parser #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .push_data_o(push_data)
  );

  bmmf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .status_o   (q_status)
  );

  bmmf_emitter u_emitter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .status_i   (q_status),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Records only come from accepted, non-start words
  a_push_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (accept && !in_data_i.start_req))
    else $error("record pushed without a matching word transfer");

  // Fill level never passes the depth
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue overflow");

  // A pop always finds data
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("queue underflow");

  // A start word clears the slot numbering
  a_slot_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.start_req) |=> (push_data.slot == '0))
    else $error("slot count not cleared by start");

endmodule
